>>> hdl/txfap_pkg.sv
// ----------------------------------------------------------------------------
// Transmit frame packer package
// Shared codes, records and index helpers of the transmit frame packer.
// ----------------------------------------------------------------------------
package txfap_pkg;

	localparam int MAX_BUFFERS    = 32;
	localparam int MAX_FRAMES     = 63;
	localparam int MAX_ALIGN_LOG2 = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam int RST_FRAMES_INT = 8;
	localparam int RST_ALIGN_INT  = 2;

	localparam logic [5:0]  RST_FRAMES_PER_BUF = 6'(RST_FRAMES_INT);
	localparam logic [2:0]  RST_ALIGN_LOG2     = 3'(RST_ALIGN_INT);
	localparam logic [15:0] RST_BUFFER_LEN     = 16'd4096;
	localparam logic [5:0]  RST_NUM_BUFFERS    = 6'd8;
	localparam logic [5:0]  RST_HIGH_WATER     = 6'd5;
	localparam logic [5:0]  RST_LOW_WATER      = 6'd4;
	localparam logic [15:0] RST_INIT_OFFSET    = 16'(((RST_FRAMES_INT + 1) * 8)
		+ (((RST_FRAMES_INT + 1) * 8) % (1 << RST_ALIGN_INT)));

	typedef enum logic [1:0] {
		OP_PLACE,
		OP_RELEASE,
		OP_FLUSH,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		KIND_DESC,
		KIND_CLOSED,
		KIND_RING_FULL,
		KIND_OVERSIZE,
		KIND_FLOW_OFF,
		KIND_FLOW_ON,
		KIND_KICK
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAMES_PER_BUF,
		CFG_ALIGN_LOG2,
		CFG_BUFFER_LEN,
		CFG_NUM_BUFFERS,
		CFG_HIGH_WATER,
		CFG_LOW_WATER
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0]  ring_size;
		logic [5:0]  frames_lim;
		logic [5:0]  align_mask;
		logic [15:0] buffer_len;
		logic [5:0]  high_water;
		logic [5:0]  low_water;
		logic [15:0] init_offset;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic        flush;
		logic [15:0] payload_len;
		logic [7:0]  header_len;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  buffer_index;
		logic [5:0]  slot;
		logic [15:0] offset;
		logic [15:0] frame_len;
		logic [5:0]  pad;
		logic        last;
	} res_t;

	function automatic logic [4:0] next_idx(input logic [4:0] idx, input logic [5:0] size);
		logic [5:0] sum;
		sum = {1'b0, idx} + 6'd1;
		return (sum == size) ? 5'd0 : sum[4:0];
	endfunction

	function automatic logic [5:0] used_cnt(input logic [4:0] w, input logic [4:0] r,
		input logic [5:0] size);
		logic [5:0] we;
		logic [5:0] re;
		we = {1'b0, w};
		re = {1'b0, r};
		return (we >= re) ? (we - re) : (we + size - re);
	endfunction

endpackage

>>> hdl/txfap_fifo.sv
// ----------------------------------------------------------------------------
// Transmit frame packer queue
// Small first-in first-out queue in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module txfap_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hdl/txfap_cfg.sv
// ----------------------------------------------------------------------------
// Transmit frame packer configuration
// Register file with saturated views and the initial descriptor area offset.
// ----------------------------------------------------------------------------
module txfap_cfg import txfap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic                  cfg_upd
);

	logic [5:0]  frames_per_buf_q;
	logic [2:0]  align_log2_q;
	logic [15:0] buffer_len_q;
	logic [5:0]  num_buffers_q;
	logic [5:0]  high_water_q;
	logic [5:0]  low_water_q;
	logic        upd_q;
	logic [2:0]  align_sat;
	logic [6:0]  align_bytes;
	logic [9:0]  desc_area;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_per_buf_q <= RST_FRAMES_PER_BUF;
			align_log2_q     <= RST_ALIGN_LOG2;
			buffer_len_q     <= RST_BUFFER_LEN;
			num_buffers_q    <= RST_NUM_BUFFERS;
			high_water_q     <= RST_HIGH_WATER;
			low_water_q      <= RST_LOW_WATER;
			upd_q            <= 1'b0;
		end else begin
			upd_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FRAMES_PER_BUF: begin
						frames_per_buf_q <= cfg_data[5:0];
						upd_q            <= 1'b1;
					end
					CFG_ALIGN_LOG2: begin
						align_log2_q <= cfg_data[2:0];
						upd_q        <= 1'b1;
					end
					CFG_BUFFER_LEN: begin
						buffer_len_q <= cfg_data;
						upd_q        <= 1'b1;
					end
					CFG_NUM_BUFFERS: begin
						num_buffers_q <= cfg_data[5:0];
						upd_q         <= 1'b1;
					end
					CFG_HIGH_WATER: begin
						high_water_q <= cfg_data[5:0];
						upd_q        <= 1'b1;
					end
					CFG_LOW_WATER: begin
						low_water_q <= cfg_data[5:0];
						upd_q       <= 1'b1;
					end
					default: upd_q <= 1'b0;
				endcase
			end
		end
	end

	assign align_sat   = (align_log2_q > 3'(MAX_ALIGN_LOG2)) ? 3'(MAX_ALIGN_LOG2) : align_log2_q;
	assign align_bytes = 7'd1 << align_sat;

	always_comb begin
		cfg = '0;
		if (num_buffers_q < 6'd2) begin
			cfg.ring_size = 6'd2;
		end else if (num_buffers_q > 6'(MAX_BUFFERS)) begin
			cfg.ring_size = 6'(MAX_BUFFERS);
		end else begin
			cfg.ring_size = num_buffers_q;
		end
		cfg.frames_lim = (frames_per_buf_q > 6'(MAX_FRAMES)) ? 6'(MAX_FRAMES) : frames_per_buf_q;
		cfg.align_mask = 6'(align_bytes - 7'd1);
		cfg.buffer_len = buffer_len_q;
		cfg.high_water = high_water_q;
		cfg.low_water  = low_water_q;
		desc_area      = ({4'd0, cfg.frames_lim} + 10'd1) << 3;
		cfg.init_offset = 16'(desc_area + (desc_area & {4'd0, cfg.align_mask}));
	end

	assign cfg_upd   = upd_q;

endmodule

>>> hdl/txfap_front.sv
// ----------------------------------------------------------------------------
// Transmit frame packer front end
// Accepts requests, drops unused op codes and queues classified commands.
// ----------------------------------------------------------------------------
module txfap_front import txfap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [1:0]  op,
	input  logic [15:0] payload_len,
	input  logic [7:0]  header_len,
	input  logic        urgent,
	output logic        full,
	output logic        cmd_push,
	output cmd_t        cmd_data,
	input  logic        cmd_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;
	logic accept;

	always_comb begin
		cmd_in             = '0;
		cmd_in.op          = op_t'(op);
		cmd_in.flush       = (cmd_in.op == OP_FLUSH) || ((cmd_in.op == OP_PLACE) && urgent);
		cmd_in.payload_len = payload_len;
		cmd_in.header_len  = header_len;
	end

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (cmd_in.op != OP_NONE);
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

>>> hdl/txfap_back.sv
// ----------------------------------------------------------------------------
// Transmit frame packer back end
// Ring and buffer state, frame placement, flow hysteresis and kicks.
// ----------------------------------------------------------------------------
module txfap_back import txfap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cfg_upd,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res,
	input  logic res_full
);

	typedef enum logic [2:0] {
		ST_NORM,
		ST_FIT,
		ST_RFULL,
		ST_FLOW,
		ST_CLOSE,
		ST_KICK
	} state_t;

	function automatic state_t tail_next(input logic [4:0] w, input logic [4:0] r,
		input logic [5:0] fc, input logic open, input logic flush, input logic fe,
		input cfg_t c);
		logic [5:0] used;
		logic       chg;
		used = used_cnt(w, r, c.ring_size);
		chg  = ((used > c.high_water) && fe) || ((used <= c.low_water) && !fe);
		if (chg) return ST_FLOW;
		if (flush && open && (fc != 6'd0)) return ST_CLOSE;
		if (flush) return ST_KICK;
		return ST_NORM;
	endfunction

	state_t      state_q, state_d, nxt;
	logic [4:0]  w_q, w_d;
	logic [4:0]  r_q, r_d;
	logic [5:0]  fc_q, fc_d;
	logic [15:0] fill_q, fill_d;
	logic        fe_q, fe_d;
	logic        open_q, open_d;
	logic        flush_q, flush_d;
	logic        emit;
	logic        pop_req;
	logic        go;

	logic [5:0]  s;
	logic [5:0]  w_sub;
	logic [5:0]  r_sub;
	logic        w_big;
	logic        r_big;
	logic [4:0]  r_rel;
	logic [4:0]  r_eff;
	logic        full_now;
	logic [4:0]  w_adv;
	logic        full_after;
	logic        full_cur;
	logic [16:0] mask17;
	logic [16:0] rounded;
	logic [5:0]  pad_v;
	logic [16:0] flen;
	logic [17:0] fend;
	logic        room;
	logic        fits;
	logic [15:0] fill_rnd;
	logic [15:0] fill_eff;
	logic [5:0]  fc_inc;
	logic [5:0]  used_now;
	logic        off_now;

	assign s          = cfg.ring_size;
	assign w_big      = ({1'b0, w_q} >= s);
	assign r_big      = ({1'b0, r_q} >= s);
	assign w_sub      = {1'b0, w_q} - s;
	assign r_sub      = {1'b0, r_q} - s;
	assign r_rel      = (w_q != r_q) ? next_idx(r_q, s) : r_q;
	assign r_eff      = (cmd.op == OP_RELEASE) ? r_rel : r_q;
	assign w_adv      = next_idx(w_q, s);
	assign full_now   = (w_adv == r_eff);
	assign full_cur   = (w_adv == r_q);
	assign full_after = (next_idx(w_adv, s) == r_q);

	assign mask17   = {11'd0, cfg.align_mask};
	assign rounded  = ({1'b0, fill_q} + mask17) & ~mask17;
	assign pad_v    = (6'd0 - (rounded[5:0] + 6'd1 + cmd.header_len[5:0])) & cfg.align_mask;
	assign flen     = 17'd1 + {11'd0, pad_v} + {1'b0, cmd.payload_len};
	assign fend     = {1'b0, rounded} + {1'b0, flen};
	assign room     = (fc_q < cfg.frames_lim);
	assign fits     = room && (fend <= {2'd0, cfg.buffer_len});
	assign fill_rnd = rounded[16] ? 16'hFFFF : rounded[15:0];
	assign fill_eff = room ? fill_rnd : fill_q;
	assign fc_inc   = fc_q + 6'd1;
	assign used_now = used_cnt(w_q, r_q, s);
	assign off_now  = (used_now > cfg.high_water) && fe_q;

	always_comb begin
		state_d = state_q;
		w_d     = w_q;
		r_d     = r_q;
		fc_d    = fc_q;
		fill_d  = fill_q;
		fe_d    = fe_q;
		open_d  = open_q;
		flush_d = flush_q;
		emit    = 1'b0;
		pop_req = 1'b0;
		nxt     = ST_NORM;
		res     = '0;
		case (state_q)
			ST_NORM: begin
				if (cmd_valid) begin
					if (w_big || r_big) begin
						if (w_big) w_d = w_sub[4:0];
						if (r_big) r_d = r_sub[4:0];
					end else begin
						r_d     = r_eff;
						open_d  = !full_now;
						flush_d = cmd.flush;
						if (cmd.op == OP_PLACE) begin
							state_d = full_now ? ST_RFULL : ST_FIT;
						end else begin
							nxt     = tail_next(w_q, r_eff, fc_q, !full_now, cmd.flush, fe_q, cfg);
							state_d = nxt;
							pop_req = (nxt == ST_NORM);
						end
					end
				end
			end
			ST_FIT: begin
				emit             = 1'b1;
				res.buffer_index = w_q;
				if (fits) begin
					res.kind      = KIND_DESC;
					res.slot      = fc_q;
					res.offset    = rounded[15:0];
					res.frame_len = flen[15:0];
					res.pad       = pad_v;
					fc_d          = fc_inc;
					fill_d        = fend[15:0];
					nxt           = tail_next(w_q, r_q, fc_inc, 1'b1, flush_q, fe_q, cfg);
					state_d       = nxt;
					pop_req       = (nxt == ST_NORM);
					res.last      = (nxt == ST_NORM);
				end else if (fc_q == 6'd0) begin
					res.kind = KIND_OVERSIZE;
					fill_d   = fill_eff;
					nxt      = tail_next(w_q, r_q, 6'd0, 1'b1, flush_q, fe_q, cfg);
					state_d  = nxt;
					pop_req  = (nxt == ST_NORM);
					res.last = (nxt == ST_NORM);
				end else begin
					res.kind   = KIND_CLOSED;
					res.offset = fill_eff;
					w_d        = w_adv;
					fc_d       = 6'd0;
					fill_d     = cfg.init_offset;
					state_d    = full_after ? ST_RFULL : ST_FIT;
				end
			end
			ST_RFULL: begin
				emit             = 1'b1;
				res.kind         = KIND_RING_FULL;
				res.buffer_index = w_q;
				open_d           = 1'b0;
				nxt              = tail_next(w_q, r_q, fc_q, 1'b0, flush_q, fe_q, cfg);
				state_d          = nxt;
				pop_req          = (nxt == ST_NORM);
				res.last         = (nxt == ST_NORM);
			end
			ST_FLOW: begin
				emit     = 1'b1;
				res.kind = off_now ? KIND_FLOW_OFF : KIND_FLOW_ON;
				fe_d     = !off_now;
				if (flush_q && open_q && (fc_q != 6'd0)) begin
					state_d = ST_CLOSE;
				end else if (flush_q || off_now) begin
					state_d = ST_KICK;
				end else begin
					state_d  = ST_NORM;
					pop_req  = 1'b1;
					res.last = 1'b1;
				end
			end
			ST_CLOSE: begin
				emit             = 1'b1;
				res.kind         = KIND_CLOSED;
				res.buffer_index = w_q;
				res.offset       = fill_q;
				if (!full_cur) w_d = w_adv;
				fc_d             = 6'd0;
				fill_d           = cfg.init_offset;
				state_d          = ST_KICK;
			end
			ST_KICK: begin
				emit     = 1'b1;
				res.kind = KIND_KICK;
				res.last = 1'b1;
				state_d  = ST_NORM;
				pop_req  = 1'b1;
			end
			default: state_d = ST_NORM;
		endcase
	end

	assign go       = !emit || !res_full;
	assign res_push = emit && go;
	assign cmd_pop  = pop_req && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORM;
			w_q     <= 5'd0;
			r_q     <= 5'd0;
			fc_q    <= 6'd0;
			fill_q  <= RST_INIT_OFFSET;
			fe_q    <= 1'b1;
			open_q  <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			if (go) begin
				state_q <= state_d;
				w_q     <= w_d;
				r_q     <= r_d;
				fc_q    <= fc_d;
				fe_q    <= fe_d;
				open_q  <= open_d;
				flush_q <= flush_d;
			end
			if (cfg_upd && (fc_q == 6'd0)) begin
				fill_q <= cfg.init_offset;
			end else if (go) begin
				fill_q <= fill_d;
			end
		end
	end

endmodule

>>> hdl/tx_frame_aggregation_packer_unit.sv
// ----------------------------------------------------------------------------
// Transmit frame aggregation packer
// Packs frame requests into a ring of shared buffers and reports descriptors,
// buffer closes, drops, flow changes and kicks as a stream of results.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full: op, payload_len, header_len, urgent.
//   Results leave through empty/pop, oldest first; last marks the final
//   result that a request causes. Unused op codes are dropped on entry.
//   Configuration registers are written through cfg_write/cfg_index/cfg_data
//   while no request is in flight; writes take effect in the next cycle.
// Sequence:
//   A request passes the front end register, the command queue, the back
//   end and the result queue. The back end emits one result per cycle when
//   the result queue has room; a fitting frame passes dispatch and fit, a
//   release with no result only dispatch. After a ring size change an index
//   past the ring drops by its size once per cycle while a command waits.
// Reset and stall:
//   Reset empties both queues, loads the register defaults, rewinds the ring
//   and turns flow on. When pop stays low the result queue fills, the back
//   end holds, the command queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module tx_frame_aggregation_packer_unit import txfap_pkg::*; #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            op,
	input  logic [15:0]           payload_len,
	input  logic [7:0]            header_len,
	input  logic                  urgent,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            kind,
	output logic [4:0]            buffer_index,
	output logic [5:0]            slot,
	output logic [15:0]           offset,
	output logic [15:0]           frame_len,
	output logic [5:0]            pad,
	output logic                  last,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg;
	logic                  cfg_upd;
	logic                  cmd_push;
	cmd_t                  cmd_in;
	logic                  cmd_full;
	logic                  cmd_empty;
	logic                  cmd_pop;
	logic [$bits(cmd_t)-1:0] cmd_rdata;
	cmd_t                  cmd_head;
	logic                  res_push;
	res_t                  res_in;
	logic                  res_full;
	logic [$bits(res_t)-1:0] res_rdata;
	res_t                  res_head;

	txfap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cfg_upd   (cfg_upd)
	);

	txfap_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.op          (op),
		.payload_len (payload_len),
		.header_len  (header_len),
		.urgent      (urgent),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_in),
		.cmd_full    (cmd_full)
	);

	txfap_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign cmd_head = cmd_t'(cmd_rdata);

	txfap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_upd   (cfg_upd),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	txfap_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head     = res_t'(res_rdata);
	assign kind         = res_head.kind;
	assign buffer_index = res_head.buffer_index;
	assign slot         = res_head.slot;
	assign offset       = res_head.offset;
	assign frame_len    = res_head.frame_len;
	assign pad          = res_head.pad;
	assign last         = res_head.last;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue written while full");

	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue written while full");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command retired with empty queue");

	a_res_visible: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("queued result not visible");

endmodule
